### rtl/core/nearest_point_color_mapper_unit_macros.svh
// Assertion macros for the nearest point color mapper.
// Included by the top level; no other dependencies.
`ifndef NEAREST_POINT_COLOR_MAPPER_UNIT_MACROS_SVH
`define NEAREST_POINT_COLOR_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define NPCM_ASSERT_NOW(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define NPCM_ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

### rtl/core/npcm_pkg.sv
// Shared widths, command and register codes, and link structs of the color mapper.
// No dependencies.
`default_nettype none

package npcm_pkg;

   localparam int CMD_W      = 2;
   localparam int SLOT_W     = 8;
   localparam int COORD_W    = 16;
   localparam int LABEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 3 * CHAN_W;
   localparam int SQ_W       = 32;
   localparam int DIST_W     = SQ_W + 1;
   localparam int PCOUNT_W   = 9;
   localparam int ICOUNT_W   = 5;
   localparam int PIXEL_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CMD_W-1:0] CMD_LOAD_POINT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_INTERVAL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY         = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LEVEL    = 2'd2;

   localparam logic [CHAN_W-1:0] ALPHA_RESET = 8'hFF;

   typedef struct packed {
      logic                      point_we;
      logic                      interval_we;
      logic [SLOT_W-1:0]         slot;
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [LABEL_W-1:0]        word;
      logic [COLOR_W-1:0]        color;
   } load_type;

   typedef struct packed {
      logic                      valid;
      logic                      found;
      logic [DIST_W-1:0]         distance;
      logic [SLOT_W-1:0]         slot;
      logic [LABEL_W-1:0]        label;
   } best_type;

   typedef struct packed {
      logic                      valid;
      logic                      found;
      logic                      hit;
      logic [SLOT_W-1:0]         slot;
      logic [LABEL_W-1:0]        label;
      logic [COLOR_W-1:0]        color;
   } probe_type;

endpackage

`default_nettype wire

### rtl/core/npcm_channels.sv
// Valid/ready channel interfaces: query/load words, result words, register writes.
// Depends on npcm_pkg.
`default_nettype none

interface npcm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [npcm_pkg::CMD_W-1:0]            command;
   logic [npcm_pkg::SLOT_W-1:0]           slot;
   logic signed [npcm_pkg::COORD_W-1:0]   coord_x;
   logic signed [npcm_pkg::COORD_W-1:0]   coord_y;
   logic signed [npcm_pkg::LABEL_W-1:0]   label_or_limit;
   logic [npcm_pkg::CHAN_W-1:0]           red;
   logic [npcm_pkg::CHAN_W-1:0]           green;
   logic [npcm_pkg::CHAN_W-1:0]           blue;

   modport source (output valid, command, slot, coord_x, coord_y, label_or_limit,
                   red, green, blue, input ready);
   modport sink   (input valid, command, slot, coord_x, coord_y, label_or_limit,
                   red, green, blue, output ready);
endinterface

interface npcm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [npcm_pkg::PIXEL_W-1:0]          pixel_word;
   logic [npcm_pkg::SLOT_W-1:0]           nearest_slot;
   logic signed [npcm_pkg::LABEL_W-1:0]   nearest_label;

   modport source (output valid, pixel_word, nearest_slot, nearest_label, input ready);
   modport sink   (input valid, pixel_word, nearest_slot, nearest_label, output ready);
endinterface

interface npcm_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [npcm_pkg::CSR_IDX_W-1:0]        index;
   logic [npcm_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/npcm_point_cell.sv
// One sample-point cell: holds a point, squares its distance to the query,
// and passes the running nearest point on. Depends on npcm_pkg.
`default_nettype none

module npcm_point_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire npcm_pkg::load_type                load,
   input  wire logic [npcm_pkg::COORD_W-1:0]      query_x,
   input  wire logic [npcm_pkg::COORD_W-1:0]      query_y,
   input  wire logic [npcm_pkg::PCOUNT_W-1:0]     point_count,
   input  wire npcm_pkg::best_type                best_in,
   output npcm_pkg::best_type                     best_out
);

   localparam logic [npcm_pkg::SLOT_W-1:0] CELL_SLOT = npcm_pkg::SLOT_W'(INDEX);

   logic [npcm_pkg::COORD_W-1:0]        px_ff;
   logic [npcm_pkg::COORD_W-1:0]        py_ff;
   logic [npcm_pkg::LABEL_W-1:0]        label_ff;
   logic                                load_hit;
   logic                                active;
   logic signed [npcm_pkg::COORD_W:0]   dx;
   logic signed [npcm_pkg::COORD_W:0]   dy;
   logic signed [2*npcm_pkg::COORD_W+1:0] dx_sq;
   logic signed [2*npcm_pkg::COORD_W+1:0] dy_sq;
   logic [npcm_pkg::SQ_W-1:0]           sqx_in;
   logic [npcm_pkg::SQ_W-1:0]           sqy_in;
   logic [npcm_pkg::SQ_W-1:0]           sqx_ff;
   logic [npcm_pkg::SQ_W-1:0]           sqy_ff;
   logic [npcm_pkg::DIST_W-1:0]         distance;
   logic                                take;
   npcm_pkg::best_type                  stage_ff;
   npcm_pkg::best_type                  out_in;
   npcm_pkg::best_type                  out_ff;

   assign load_hit = load.point_we && ({24'd0, load.slot} == 32'(INDEX));
   assign active   = {23'd0, point_count} > 32'(INDEX);

   always_comb begin
      dx     = $signed({query_x[npcm_pkg::COORD_W-1], query_x}) -
               $signed({px_ff[npcm_pkg::COORD_W-1], px_ff});
      dy     = $signed({query_y[npcm_pkg::COORD_W-1], query_y}) -
               $signed({py_ff[npcm_pkg::COORD_W-1], py_ff});
      dx_sq  = dx * dx;
      dy_sq  = dy * dy;
      sqx_in = dx_sq[npcm_pkg::SQ_W-1:0];
      sqy_in = dy_sq[npcm_pkg::SQ_W-1:0];
   end

   always_comb begin
      distance = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      take     = active && (!stage_ff.found || (distance < stage_ff.distance));
      out_in   = stage_ff;
      if (take) begin
         out_in.found    = 1'b1;
         out_in.distance = distance;
         out_in.slot     = CELL_SLOT;
         out_in.label    = label_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         px_ff    <= load.x;
         py_ff    <= load.y;
         label_ff <= load.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         out_ff.valid   <= 1'b0;
      end else begin
         stage_ff <= best_in;
         out_ff   <= out_in;
      end
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
   end

   assign best_out = out_ff;

endmodule

`default_nettype wire

### rtl/core/npcm_interval_cell.sv
// One color-interval cell: holds a limit and color, and claims the label when it is the
// first interval in use at or above it, or the last interval in use. Depends on npcm_pkg.
`default_nettype none

module npcm_interval_cell #(
   parameter int INDEX = 0,
   parameter bit LAST  = 1'b0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire npcm_pkg::load_type                load,
   input  wire logic [npcm_pkg::ICOUNT_W-1:0]     interval_count,
   input  wire npcm_pkg::probe_type               probe_in,
   output npcm_pkg::probe_type                    probe_out
);

   logic [npcm_pkg::LABEL_W-1:0]  limit_ff;
   logic [npcm_pkg::COLOR_W-1:0]  color_ff;
   logic                          load_hit;
   logic                          active;
   logic                          is_last;
   logic                          take;
   npcm_pkg::probe_type           out_in;
   npcm_pkg::probe_type           out_ff;

   assign load_hit = load.interval_we && ({24'd0, load.slot} == 32'(INDEX));
   assign active   = {27'd0, interval_count} > 32'(INDEX);
   assign is_last  = LAST ? active : ({27'd0, interval_count} == 32'(INDEX + 1));

   always_comb begin
      take   = active && !probe_in.hit &&
               (($signed(probe_in.label) <= $signed(limit_ff)) || is_last);
      out_in = probe_in;
      if (take) begin
         out_in.hit   = 1'b1;
         out_in.color = color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         limit_ff <= load.word;
         color_ff <= load.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign probe_out = out_ff;

endmodule

`default_nettype wire

### rtl/core/nearest_point_color_mapper_unit.sv
// Top level of the nearest point color mapper: point cell chain, interval cell chain,
// control and registers. Depends on npcm_pkg, npcm_channels, both cell modules, macros.
//
//   channel   dir   word
//   req_ch    in    command, slot, coord_x, coord_y, label_or_limit, red, green, blue
//   rsp_ch    out   pixel_word, nearest_slot, nearest_label
//   csr_ch    in    index, data (point_count, interval_count, alpha_level)
//
// A load word does not hold the block. A query word holds it until its result leaves the
// chain: each point cell registers the difference and square, then the sum and compare,
// and then each interval cell in turn registers its limit compare.
// Reset clears the counts and sets alpha to 255; stored points and intervals are kept.
// A result waiting on rsp_ch does not block input; a query that finishes while it still
// waits parks in a hold stage and blocks req_ch until rsp_ch takes the waiting word.
`default_nettype none
`include "nearest_point_color_mapper_unit_macros.svh"

module nearest_point_color_mapper_unit #(
   parameter int POINTS    = 256,
   parameter int INTERVALS = 16
) (
   input  wire logic      clock,
   input  wire logic      reset,
   npcm_req_if.sink       req_ch,
   npcm_rsp_if.source     rsp_ch,
   npcm_csr_if.sink       csr_ch
);

   typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_HOLD} state_type;

   state_type                              state_ff;
   logic [npcm_pkg::PCOUNT_W-1:0]          point_count_ff;
   logic [npcm_pkg::ICOUNT_W-1:0]          interval_count_ff;
   logic [npcm_pkg::CHAN_W-1:0]            alpha_ff;
   logic                                   go_ff;
   logic [npcm_pkg::COORD_W-1:0]           query_x_ff;
   logic [npcm_pkg::COORD_W-1:0]           query_y_ff;
   logic                                   rsp_valid_ff;
   logic [npcm_pkg::PIXEL_W-1:0]           pixel_ff;
   logic [npcm_pkg::SLOT_W-1:0]            slot_ff;
   logic [npcm_pkg::LABEL_W-1:0]           label_ff;
   logic [npcm_pkg::PIXEL_W-1:0]           hold_pixel_ff;
   logic [npcm_pkg::SLOT_W-1:0]            hold_slot_ff;
   logic [npcm_pkg::LABEL_W-1:0]           hold_label_ff;
   logic                                   req_fire;
   logic                                   query_fire;
   logic                                   out_free;
   logic                                   rsp_load;
   logic                                   chain_done;
   logic [npcm_pkg::COLOR_W-1:0]           color;
   logic [npcm_pkg::CHAN_W-1:0]            alpha_sel;
   logic [npcm_pkg::PIXEL_W-1:0]           pixel_in;
   npcm_pkg::load_type                     load_bus;
   npcm_pkg::best_type                     best_head;
   npcm_pkg::probe_type                    probe_head;
   npcm_pkg::probe_type                    probe_tail;
   npcm_pkg::best_type                     best_link  [POINTS+1];
   npcm_pkg::probe_type                    probe_link [INTERVALS+1];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign query_fire   = req_fire && (req_ch.command == npcm_pkg::CMD_QUERY);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      load_bus.point_we    = req_fire && (req_ch.command == npcm_pkg::CMD_LOAD_POINT);
      load_bus.interval_we = req_fire && (req_ch.command == npcm_pkg::CMD_LOAD_INTERVAL);
      load_bus.slot        = req_ch.slot;
      load_bus.x           = req_ch.coord_x;
      load_bus.y           = req_ch.coord_y;
      load_bus.word        = req_ch.label_or_limit;
      load_bus.color       = {req_ch.red, req_ch.green, req_ch.blue};
   end

   always_comb begin
      best_head       = '0;
      best_head.valid = go_ff;
   end

   assign best_link[0] = best_head;

   for (genvar n = 0; n < POINTS; n++) begin : g_point
      npcm_point_cell #(
         .INDEX (n)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .load        (load_bus),
         .query_x     (query_x_ff),
         .query_y     (query_y_ff),
         .point_count (point_count_ff),
         .best_in     (best_link[n]),
         .best_out    (best_link[n+1])
      );
   end

   always_comb begin
      probe_head       = '0;
      probe_head.valid = best_link[POINTS].valid;
      probe_head.found = best_link[POINTS].found;
      probe_head.slot  = best_link[POINTS].slot;
      probe_head.label = best_link[POINTS].label;
   end

   assign probe_link[0] = probe_head;

   for (genvar i = 0; i < INTERVALS; i++) begin : g_interval
      npcm_interval_cell #(
         .INDEX (i),
         .LAST  (i == INTERVALS - 1)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .load           (load_bus),
         .interval_count (interval_count_ff),
         .probe_in       (probe_link[i]),
         .probe_out      (probe_link[i+1])
      );
   end

   assign probe_tail = probe_link[INTERVALS];
   assign chain_done = probe_tail.valid;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load   = ((state_ff == ST_BUSY) && chain_done && out_free) ||
                       ((state_ff == ST_HOLD) && out_free);

   always_comb begin
      color     = probe_tail.color;
      alpha_sel = (color == '0) ? '0 : alpha_ff;
      pixel_in  = '0;
      if (probe_tail.found && probe_tail.hit) begin
         pixel_in = {alpha_sel, color[7:0], color[15:8], color[23:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff    <= '0;
         interval_count_ff <= '0;
         alpha_ff          <= npcm_pkg::ALPHA_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            npcm_pkg::CSR_POINT_COUNT: begin
               point_count_ff <= csr_ch.data[npcm_pkg::PCOUNT_W-1:0];
            end
            npcm_pkg::CSR_INTERVAL_COUNT: begin
               interval_count_ff <= csr_ch.data[npcm_pkg::ICOUNT_W-1:0];
            end
            npcm_pkg::CSR_ALPHA_LEVEL: begin
               alpha_ff <= csr_ch.data[npcm_pkg::CHAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         go_ff <= query_fire;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (query_fire) begin
                  query_x_ff <= req_ch.coord_x;
                  query_y_ff <= req_ch.coord_y;
                  state_ff   <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               if (chain_done) begin
                  if (out_free) begin
                     pixel_ff     <= pixel_in;
                     slot_ff      <= probe_tail.slot;
                     label_ff     <= probe_tail.label;
                     state_ff     <= ST_IDLE;
                  end else begin
                     hold_pixel_ff <= pixel_in;
                     hold_slot_ff  <= probe_tail.slot;
                     hold_label_ff <= probe_tail.label;
                     state_ff      <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (out_free) begin
                  pixel_ff     <= hold_pixel_ff;
                  slot_ff      <= hold_slot_ff;
                  label_ff     <= hold_label_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pixel_word    = pixel_ff;
   assign rsp_ch.nearest_slot  = slot_ff;
   assign rsp_ch.nearest_label = label_ff;

   `NPCM_ASSERT_NOW(a_done_in_busy, clock, reset, chain_done, state_ff == ST_BUSY, "query left the chain outside a query")
   `NPCM_ASSERT_NOW(a_hold_has_word, clock, reset, state_ff == ST_HOLD, rsp_valid_ff, "hold stage filled while output was free")
   `NPCM_ASSERT_NEXT(a_hold_stays, clock, reset, (state_ff == ST_HOLD) && !rsp_ch.ready, state_ff == ST_HOLD, "hold stage dropped a stalled word")
   `NPCM_ASSERT_NOW(a_rsp_from_query, clock, reset, $rose(rsp_valid_ff), ($past(state_ff) == ST_BUSY) || ($past(state_ff) == ST_HOLD), "result word without a query")

endmodule

`default_nettype wire

### test/nearest_point_color_mapper_unit_test.sv
// Self-checking test of the nearest point color mapper: a directed stimulus table,
// a full load of points and intervals, then random phases under changing register settings.
// Depends on npcm_pkg, npcm_channels and the nearest_point_color_mapper_unit RTL.
`default_nettype none

module nearest_point_color_mapper_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POINTS    = 256;
   localparam int INTERVALS = 16;
   localparam int ITEMS     = 650;
   localparam int DRAIN     = 2 * POINTS + INTERVALS + 16;
   localparam int LIMIT     = 1_500_000;
   localparam int HOLD_OFF  = 3000;

   localparam logic [npcm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [npcm_pkg::CMD_W-1:0]          command;
      logic [npcm_pkg::SLOT_W-1:0]         slot;
      logic signed [npcm_pkg::COORD_W-1:0] coord_x;
      logic signed [npcm_pkg::COORD_W-1:0] coord_y;
      logic signed [npcm_pkg::LABEL_W-1:0] label_or_limit;
      logic [npcm_pkg::CHAN_W-1:0]         red;
      logic [npcm_pkg::CHAN_W-1:0]         green;
      logic [npcm_pkg::CHAN_W-1:0]         blue;
   } req_word_type;

   typedef struct packed {
      logic [npcm_pkg::PIXEL_W-1:0]        pixel_word;
      logic [npcm_pkg::SLOT_W-1:0]         nearest_slot;
      logic signed [npcm_pkg::LABEL_W-1:0] nearest_label;
   } pixel_result_type;

   typedef struct {
      bit                              is_setting;
      logic [npcm_pkg::PCOUNT_W-1:0]   pc;
      logic [npcm_pkg::ICOUNT_W-1:0]   ic;
      logic [npcm_pkg::CHAN_W-1:0]     al;
      req_word_type                    w;
      bit                              typed;
      pixel_result_type                expected;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   npcm_req_if req_ch ();
   npcm_rsp_if rsp_ch ();
   npcm_csr_if csr_ch ();

   nearest_point_color_mapper_unit #(
      .POINTS    (POINTS),
      .INTERVALS (INTERVALS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   logic signed [npcm_pkg::COORD_W-1:0] site_x     [POINTS];
   logic signed [npcm_pkg::COORD_W-1:0] site_y     [POINTS];
   logic signed [npcm_pkg::LABEL_W-1:0] site_label [POINTS];
   logic signed [npcm_pkg::LABEL_W-1:0] band_limit [INTERVALS];
   logic [npcm_pkg::COLOR_W-1:0]        band_rgb   [INTERVALS];
   logic [npcm_pkg::PCOUNT_W-1:0]       site_count  = '0;
   logic [npcm_pkg::ICOUNT_W-1:0]       band_count  = '0;
   logic [npcm_pkg::CHAN_W-1:0]         alpha_level = npcm_pkg::ALPHA_RESET;

   pixel_result_type awaited_pixels [$];
   script_row_type   script [$];
   int unsigned      errors      = 0;
   int unsigned      words_sent  = 0;
   int unsigned      burst_left  = 0;
   int unsigned      cycle_count = 0;

   function automatic bit map_word(input req_word_type w, output pixel_result_type res);
      int unsigned np, nb, best, n;
      longint dx, dy, d, best_d;
      logic [npcm_pkg::COLOR_W-1:0] rgb;
      res = '0;
      case (w.command)
         npcm_pkg::CMD_LOAD_POINT: begin
            if (w.slot < POINTS) begin
               site_x[w.slot]     = w.coord_x;
               site_y[w.slot]     = w.coord_y;
               site_label[w.slot] = w.label_or_limit;
            end
            return 1'b0;
         end
         npcm_pkg::CMD_LOAD_INTERVAL: begin
            if (w.slot < INTERVALS) begin
               band_limit[w.slot] = w.label_or_limit;
               band_rgb[w.slot]   = {w.red, w.green, w.blue};
            end
            return 1'b0;
         end
         npcm_pkg::CMD_QUERY: ;
         default: return 1'b0;
      endcase
      np = (site_count > POINTS) ? POINTS : site_count;
      nb = (band_count > INTERVALS) ? INTERVALS : band_count;
      if (np == 0) return 1'b1;
      best   = 0;
      best_d = 0;
      for (n = 0; n < np; n++) begin
         dx = longint'($signed(w.coord_x)) - longint'($signed(site_x[n]));
         dy = longint'($signed(w.coord_y)) - longint'($signed(site_y[n]));
         d  = dx * dx + dy * dy;
         if (n == 0 || d < best_d) begin
            best_d = d;
            best   = n;
         end
      end
      res.nearest_slot  = npcm_pkg::SLOT_W'(best);
      res.nearest_label = site_label[best];
      if (nb == 0) return 1'b1;
      rgb = band_rgb[nb-1];
      for (n = 0; n < nb; n++) begin
         if ($signed(res.nearest_label) <= $signed(band_limit[n])) begin
            rgb = band_rgb[n];
            break;
         end
      end
      if (rgb != '0)
         res.pixel_word = {alpha_level, rgb[7:0], rgb[15:8], rgb[23:16]};
      return 1'b1;
   endfunction

   function automatic logic signed [npcm_pkg::COORD_W-1:0] pick_coord(input bit clustered);
      case ($urandom_range(0, 15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: begin
            if (clustered) return npcm_pkg::COORD_W'(int'($urandom_range(0, 16)) - 8);
            return npcm_pkg::COORD_W'($urandom);
         end
      endcase
   endfunction

   function automatic logic signed [npcm_pkg::LABEL_W-1:0] pick_label();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3, 4: return npcm_pkg::LABEL_W'($urandom);
         default: return npcm_pkg::LABEL_W'(int'($urandom_range(0, 80)) - 40);
      endcase
   endfunction

   function automatic req_word_type random_word(input logic [npcm_pkg::CMD_W-1:0] cmd,
                                                input bit clustered);
      req_word_type w;
      w.command = cmd;
      w.slot    = npcm_pkg::SLOT_W'($urandom_range(0, 255));
      if (cmd == npcm_pkg::CMD_LOAD_INTERVAL && $urandom_range(0, 7) != 0)
         w.slot = npcm_pkg::SLOT_W'($urandom_range(0, INTERVALS - 1));
      w.coord_x        = pick_coord(clustered);
      w.coord_y        = pick_coord(clustered);
      w.label_or_limit = pick_label();
      if ($urandom_range(0, 5) == 0)
         {w.red, w.green, w.blue} = '0;
      else
         {w.red, w.green, w.blue} = npcm_pkg::COLOR_W'($urandom);
      return w;
   endfunction

   function automatic script_row_type load_row(
         input logic [npcm_pkg::CMD_W-1:0]          cmd,
         input logic [npcm_pkg::SLOT_W-1:0]         slot,
         input logic signed [npcm_pkg::COORD_W-1:0] x,
         input logic signed [npcm_pkg::COORD_W-1:0] y,
         input logic signed [npcm_pkg::LABEL_W-1:0] lim,
         input logic [npcm_pkg::COLOR_W-1:0]        rgb);
      script_row_type row;
      row            = '{default: '0};
      row.w.command  = cmd;
      row.w.slot     = slot;
      row.w.coord_x  = x;
      row.w.coord_y  = y;
      row.w.label_or_limit = lim;
      {row.w.red, row.w.green, row.w.blue} = rgb;
      return row;
   endfunction

   function automatic script_row_type query_row(
         input logic signed [npcm_pkg::COORD_W-1:0] x,
         input logic signed [npcm_pkg::COORD_W-1:0] y,
         input bit                                  typed,
         input logic [npcm_pkg::PIXEL_W-1:0]        pixel,
         input logic [npcm_pkg::SLOT_W-1:0]         nslot,
         input logic signed [npcm_pkg::LABEL_W-1:0] nlabel);
      script_row_type row;
      row = load_row(npcm_pkg::CMD_QUERY, '0, x, y, '0, '0);
      row.typed    = typed;
      row.expected = '{pixel, nslot, nlabel};
      return row;
   endfunction

   function automatic script_row_type setting_row(input logic [npcm_pkg::PCOUNT_W-1:0] pc,
                                                  input logic [npcm_pkg::ICOUNT_W-1:0] ic,
                                                  input logic [npcm_pkg::CHAN_W-1:0] al);
      script_row_type row;
      row            = '{default: '0};
      row.is_setting = 1'b1;
      row.pc         = pc;
      row.ic         = ic;
      row.al         = al;
      return row;
   endfunction

   task automatic deliver(input req_word_type w, input bit typed,
                          input pixel_result_type typed_res);
      pixel_result_type res;
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid          <= 1'b1;
      req_ch.command        <= w.command;
      req_ch.slot           <= w.slot;
      req_ch.coord_x        <= w.coord_x;
      req_ch.coord_y        <= w.coord_y;
      req_ch.label_or_limit <= w.label_or_limit;
      req_ch.red            <= w.red;
      req_ch.green          <= w.green;
      req_ch.blue           <= w.blue;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (map_word(w, res))
         awaited_pixels.push_back(typed ? typed_res : res);
      words_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(input logic [npcm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [npcm_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic write_settings(input logic [npcm_pkg::PCOUNT_W-1:0] pc,
                                 input logic [npcm_pkg::ICOUNT_W-1:0] ic,
                                 input logic [npcm_pkg::CHAN_W-1:0] al);
      write_reg(npcm_pkg::CSR_POINT_COUNT, npcm_pkg::CSR_DATA_W'(pc));
      site_count = pc;
      write_reg(npcm_pkg::CSR_INTERVAL_COUNT, npcm_pkg::CSR_DATA_W'(ic));
      band_count = ic;
      write_reg(npcm_pkg::CSR_ALPHA_LEVEL, npcm_pkg::CSR_DATA_W'(al));
      alpha_level = al;
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int s, phase, k;
      bit clustered;
      int unsigned pick;
      req_word_type w;
      logic [npcm_pkg::PCOUNT_W-1:0] pc;
      logic [npcm_pkg::ICOUNT_W-1:0] ic;
      logic [npcm_pkg::CHAN_W-1:0] al;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.command        <= npcm_pkg::CMD_LOAD_POINT;
      req_ch.slot           <= '0;
      req_ch.coord_x        <= '0;
      req_ch.coord_y        <= '0;
      req_ch.label_or_limit <= '0;
      req_ch.red            <= '0;
      req_ch.green          <= '0;
      req_ch.blue           <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= npcm_pkg::CSR_POINT_COUNT;
      csr_ch.data           <= '0;

      script.push_back(query_row(16'sd0, 16'sd0, 1'b1, 32'h0, 8'd0, 32'sd0));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_POINT, 8'd0, 16'sh8000, 16'sh8000,
                                32'h8000_0000, '0));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_POINT, 8'd1, 16'sh7FFF, 16'sh7FFF,
                                32'h7FFF_FFFF, '0));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_POINT, 8'd2, 16'sd0, 16'sd0, 32'sd5, '0));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_POINT, 8'd3, 16'sd0, 16'sd0, 32'sd6, '0));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_INTERVAL, 8'd0, '0, '0, -32'sd100,
                                24'hFF0000));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_INTERVAL, 8'd1, '0, '0, 32'sd5,
                                24'h000000));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_INTERVAL, 8'd2, '0, '0, 32'sd100,
                                24'h123456));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_INTERVAL, 8'd200, '0, '0, 32'sd0,
                                24'hFFFFFF));
      script.push_back(load_row(CMD_UNUSED, 8'hFF, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF,
                                24'hFFFFFF));
      script.push_back(query_row(16'sd0, 16'sd0, 1'b1, 32'h0, 8'd0, 32'sd0));
      script.push_back(setting_row(9'd4, 5'd0, 8'hFF));
      script.push_back(query_row(16'sd0, 16'sd0, 1'b1, 32'h0, 8'd2, 32'sd5));
      script.push_back(query_row(16'sd1, -16'sd1, 1'b0, '0, '0, '0));
      script.push_back(setting_row(9'd4, 5'd3, 8'hFF));
      script.push_back(query_row(16'sd0, 16'sd0, 1'b1, 32'h0, 8'd2, 32'sd5));
      script.push_back(query_row(16'sh8000, 16'sh8000, 1'b1, 32'hFF00_00FF, 8'd0,
                                 32'h8000_0000));
      script.push_back(query_row(16'sh7FFF, 16'sh7FFF, 1'b1, 32'hFF56_3412, 8'd1,
                                 32'h7FFF_FFFF));
      script.push_back(query_row(16'sh8000, 16'sh7FFF, 1'b0, '0, '0, '0));
      script.push_back(setting_row(9'd1, 5'd3, 8'h00));
      script.push_back(query_row(16'sh7FFF, 16'sh7FFF, 1'b1, 32'h0000_00FF, 8'd0,
                                 32'h8000_0000));
      script.push_back(setting_row(9'd4, 5'd3, 8'h5A));
      script.push_back(load_row(npcm_pkg::CMD_LOAD_INTERVAL, 8'd2, '0, '0, 32'sd100,
                                24'hA5C30F));
      script.push_back(query_row(16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_setting) begin
            drain();
            write_settings(script[i].pc, script[i].ic, script[i].al);
         end else begin
            deliver(script[i].w, script[i].typed, script[i].expected);
         end
      end

      // fill every point and interval slot
      for (s = 0; s < POINTS; s++) begin
         w      = random_word(npcm_pkg::CMD_LOAD_POINT, s % 2 == 1);
         w.slot = npcm_pkg::SLOT_W'(s);
         deliver(w, 1'b0, '0);
      end
      for (s = 0; s < INTERVALS; s++) begin
         w      = random_word(npcm_pkg::CMD_LOAD_INTERVAL, 1'b0);
         w.slot = npcm_pkg::SLOT_W'(s);
         deliver(w, 1'b0, '0);
      end

      for (phase = 0; words_sent < ITEMS; phase++) begin
         case (phase)
            0: begin
               pc = 9'd511;
               ic = 5'd31;
               al = 8'h00;
            end
            1: begin
               pc = npcm_pkg::PCOUNT_W'(POINTS);
               ic = npcm_pkg::ICOUNT_W'(INTERVALS);
               al = 8'hFF;
            end
            2: begin
               pc = 9'd1;
               ic = 5'd1;
               al = 8'h80;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       pc = npcm_pkg::PCOUNT_W'($urandom_range(0, 3));
                  1:       pc = npcm_pkg::PCOUNT_W'($urandom_range(1, 511));
                  2:       pc = npcm_pkg::PCOUNT_W'(POINTS);
                  default: pc = npcm_pkg::PCOUNT_W'($urandom_range(2, 40));
               endcase
               case ($urandom_range(0, 3))
                  0:       ic = '0;
                  1:       ic = npcm_pkg::ICOUNT_W'(INTERVALS);
                  default: ic = npcm_pkg::ICOUNT_W'($urandom_range(1, 31));
               endcase
               al = npcm_pkg::CHAN_W'($urandom_range(0, 255));
            end
         endcase
         drain();
         write_settings(pc, ic, al);
         clustered = ($urandom_range(0, 2) != 0);
         for (k = 0; k < 40 && words_sent < ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 64)
               w = random_word(npcm_pkg::CMD_QUERY, clustered);
            else if (pick < 80)
               w = random_word(npcm_pkg::CMD_LOAD_POINT, clustered);
            else if (pick < 92)
               w = random_word(npcm_pkg::CMD_LOAD_INTERVAL, clustered);
            else
               w = random_word(CMD_UNUSED, clustered);
            deliver(w, 1'b0, '0);
         end
      end

      drain();
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : receiver
      int unsigned tick, taken, hold_left, holds;
      tick      = 0;
      taken     = 0;
      hold_left = 0;
      holds     = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (rsp_ch.valid && rsp_ch.ready) taken++;
         if (hold_left == 0 && holds < 2 && taken >= 20 + holds * 100) begin
            hold_left = HOLD_OFF;
            holds++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((tick / 97) % 4)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ch.ready <= (tick % 4 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_pixels.size() == 0) begin
            $error("unexpected result word: pixel_word %h", rsp_ch.pixel_word);
            errors++;
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_ch.pixel_word !== want.pixel_word) begin
               $error("pixel_word: expected %h, actual %h", want.pixel_word, rsp_ch.pixel_word);
               errors++;
            end
            if (rsp_ch.nearest_slot !== want.nearest_slot) begin
               $error("nearest_slot: expected %0d, actual %0d",
                      want.nearest_slot, rsp_ch.nearest_slot);
               errors++;
            end
            if (rsp_ch.nearest_label !== want.nearest_label) begin
               $error("nearest_label: expected %h, actual %h",
                      want.nearest_label, rsp_ch.nearest_label);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

`default_nettype wire
